// ===== src/rmq_pkg.sv =====
// Shared types and constants for the rotation matrix to quaternion converter.
// No dependencies; every other file in src imports this package.
`default_nettype none
package rmq_pkg;
  localparam int DATA_WIDTH = 16;
  localparam int FB         = DATA_WIDTH - 2;       // fraction bits
  localparam int ONE_INT    = 1 << FB;
  localparam logic [DATA_WIDTH-1:0] ONE_FX = DATA_WIDTH'(ONE_INT);
  localparam int CW         = DATA_WIDTH + 2;       // signed component width
  localparam int MW         = DATA_WIDTH + 2;       // component magnitude width
  localparam int NB         = 30;                   // normalised magnitude width
  localparam int TOPB       = NB - 1;               // target position of the leading one
  localparam int SHW        = 6;                    // normalising shift amount width
  localparam int SW         = 2 * NB + 2;           // sum of four squares
  localparam int RTW        = SW / 2;               // square root width
  localparam int REMW       = RTW + 2;              // root remainder width
  localparam int QB         = DATA_WIDTH - 1;       // quotient bits per lane
  localparam int NUMW       = NB + FB + 1;          // dividend width
  localparam int PW         = $clog2(MW);

  typedef logic signed [DATA_WIDTH-1:0] fx_t;
  typedef logic [NB-1:0] nmag_t;
  typedef logic [RTW-1:0] root_t;

  typedef struct packed {
    nmag_t [3:0] mag;
    logic  [3:0] neg;
    logic        inv;
  } side_t;
endpackage
`default_nettype wire

// ===== src/rmq_if.sv =====
// Handshake channels for matrix words in and quaternion words out.
// Depends on rmq_pkg.
`default_nettype none
interface rmq_mat_if;
  import rmq_pkg::*;
  logic valid;
  logic ready;
  fx_t  entry_0, entry_1, entry_2, entry_3, entry_4, entry_5, entry_6, entry_7, entry_8;
  modport source (output valid, entry_0, entry_1, entry_2, entry_3, entry_4, entry_5,
                  entry_6, entry_7, entry_8, input ready);
  modport sink (input valid, entry_0, entry_1, entry_2, entry_3, entry_4, entry_5,
                entry_6, entry_7, entry_8, output ready);
endinterface

interface rmq_quat_if;
  import rmq_pkg::*;
  logic valid;
  logic ready;
  fx_t  quat_x, quat_y, quat_z, quat_w;
  logic invalid;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, invalid, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, invalid, output ready);
endinterface
`default_nettype wire

// ===== src/rmq_front.sv =====
// Front end: branch choice, component vector, magnitude normalisation, sum of squares.
// Depends on rmq_pkg. Four register stages.
`default_nettype none
module rmq_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  rmq_pkg::fx_t [8:0]        entry,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rmq_pkg::side_t            side,
  output logic [rmq_pkg::SW-1:0]    norm_sq
);
  import rmq_pkg::*;

  logic [3:0] v;
  logic [3:0] en;

  logic signed [CW-1:0] d [9];
  logic signed [CW-1:0] trace, r;
  logic signed [CW-1:0] c [4];

  logic signed [CW-1:0] comp0 [4];
  logic                 inv0;

  logic [MW-1:0]        mag [4];
  logic [MW-1:0]        orv;
  logic [PW-1:0]        p;
  logic [SHW-1:0]       sh;
  logic [NB+MW-1:0]     ext [4];
  side_t                side_next;
  side_t                side1, side2, side3;
  logic [2*NB-1:0]      sq2 [4];
  logic [SW-1:0]        n3;

  always_comb begin
    en[3] = !v[3] || out_ready;
    for (int k = 2; k >= 0; k--) en[k] = !v[k] || en[k+1];
  end
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < 4; k++) if (en[k]) v[k] <= v[k-1];
    end
  end

  // branch choice and integer component vector
  always_comb begin
    for (int i = 0; i < 9; i++) d[i] = CW'(entry[i]);
    trace = d[0] + d[4] + d[8];
    if (trace > 0) begin
      r    = CW'(ONE_INT) + trace;
      c[0] = d[5] - d[7];
      c[1] = d[6] - d[2];
      c[2] = d[1] - d[3];
      c[3] = r;
    end else if (d[0] > d[4] && d[0] > d[8]) begin
      r    = CW'(ONE_INT) + d[0] - d[4] - d[8];
      c[0] = r;
      c[1] = d[3] + d[1];
      c[2] = d[6] + d[2];
      c[3] = d[5] - d[7];
    end else if (d[4] > d[8]) begin
      r    = CW'(ONE_INT) + d[4] - d[0] - d[8];
      c[0] = d[3] + d[1];
      c[1] = r;
      c[2] = d[7] + d[5];
      c[3] = d[6] - d[2];
    end else begin
      r    = CW'(ONE_INT) + d[8] - d[0] - d[4];
      c[0] = d[6] + d[2];
      c[1] = d[7] + d[5];
      c[2] = r;
      c[3] = d[1] - d[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 4; i++) comp0[i] <= c[i];
      inv0 <= (r <= 0);
    end
  end

  // bring the leading one of the largest magnitude to bit TOPB
  always_comb begin
    orv = '0;
    for (int i = 0; i < 4; i++) begin
      side_next.neg[i] = comp0[i][CW-1];
      mag[i] = comp0[i][CW-1] ? MW'(-comp0[i]) : MW'(comp0[i]);
      orv = orv | mag[i];
    end
    p = '0;
    for (int b = 0; b < MW; b++) if (orv[b]) p = PW'(b);
    if (SHW'(p) <= SHW'(TOPB)) sh = SHW'(TOPB) - SHW'(p);
    else sh = SHW'(p) - SHW'(TOPB);
    for (int i = 0; i < 4; i++) begin
      ext[i] = (NB+MW)'(mag[i]);
      if (SHW'(p) <= SHW'(TOPB)) ext[i] = ext[i] << sh;
      else ext[i] = ext[i] >> sh;
      side_next.mag[i] = ext[i][NB-1:0];
    end
    side_next.inv = inv0;
  end

  always_ff @(posedge clk) begin
    if (en[1]) side1 <= side_next;
    if (en[2]) begin
      side2 <= side1;
      for (int i = 0; i < 4; i++) sq2[i] <= side1.mag[i] * side1.mag[i];
    end
    if (en[3]) begin
      side3 <= side2;
      n3 <= SW'(sq2[0]) + SW'(sq2[1]) + SW'(sq2[2]) + SW'(sq2[3]);
    end
  end

  assign out_valid = v[3];
  assign side      = side3;
  assign norm_sq   = n3;
endmodule
`default_nettype wire

// ===== src/rmq_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
// Depends on rmq_pkg; carries the lane sideband alongside.
`default_nettype none
module rmq_sqrt (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  rmq_pkg::side_t         side_in,
  input  logic [rmq_pkg::SW-1:0] n_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rmq_pkg::side_t         side_out,
  output rmq_pkg::root_t         root_out
);
  import rmq_pkg::*;

  logic [RTW-1:0]  v;
  logic [RTW-1:0]  en;
  side_t           side_q [RTW];
  logic [SW-1:0]   nsh_q  [RTW];
  root_t           root_q [RTW];
  logic [REMW-1:0] rem_q  [RTW];

  always_comb begin
    en[RTW-1] = !v[RTW-1] || out_ready;
    for (int k = RTW-2; k >= 0; k--) en[k] = !v[k] || en[k+1];
  end
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < RTW; k++) if (en[k]) v[k] <= v[k-1];
    end
  end

  for (genvar k = 0; k < RTW; k++) begin : g_stage
    side_t           side_p;
    logic [SW-1:0]   nsh_p;
    root_t           root_p;
    logic [REMW-1:0] rem_p;
    logic [REMW+1:0] acc, trial;

    if (k == 0) begin : g_first
      assign side_p = side_in;
      assign nsh_p  = n_in;
      assign root_p = '0;
      assign rem_p  = '0;
    end else begin : g_next
      assign side_p = side_q[k-1];
      assign nsh_p  = nsh_q[k-1];
      assign root_p = root_q[k-1];
      assign rem_p  = rem_q[k-1];
    end

    assign acc   = {rem_p, nsh_p[SW-1:SW-2]};
    assign trial = (REMW+2)'({root_p, 2'b01});

    always_ff @(posedge clk) begin
      if (en[k]) begin
        side_q[k] <= side_p;
        nsh_q[k]  <= {nsh_p[SW-3:0], 2'b00};
        if (acc >= trial) begin
          rem_q[k]  <= REMW'(acc - trial);
          root_q[k] <= {root_p[RTW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= REMW'(acc);
          root_q[k] <= {root_p[RTW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v[RTW-1];
  assign side_out  = side_q[RTW-1];
  assign root_out  = root_q[RTW-1];
endmodule
`default_nettype wire

// ===== src/rmq_lane.sv =====
// One division lane: rounded |c| * ONE / L, one quotient bit per stage, then
// saturation and sign. Depends on rmq_pkg.
`default_nettype none
module rmq_lane (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rmq_pkg::nmag_t mag,
  input  rmq_pkg::root_t root,
  input  logic           neg,
  input  logic           inv_in,
  output logic           out_valid,
  input  logic           out_ready,
  output rmq_pkg::fx_t   value,
  output logic           inv_out
);
  import rmq_pkg::*;

  logic [QB-1:0]  v;
  logic [QB-1:0]  en;
  logic [RTW-1:0] rem_q  [QB];
  logic [QB-1:0]  low_q  [QB];
  logic [QB-1:0]  quo_q  [QB];
  root_t          root_q [QB];
  logic           neg_q  [QB];
  logic           inv_q  [QB];

  logic [NUMW-1:0] num;
  logic [QB-1:0]   sat;

  always_comb begin
    en[QB-1] = !v[QB-1] || out_ready;
    for (int k = QB-2; k >= 0; k--) en[k] = !v[k] || en[k+1];
  end
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < QB; k++) if (en[k]) v[k] <= v[k-1];
    end
  end

  // dividend with half the divisor added for round-half-up
  assign num = (NUMW'(mag) << FB) + NUMW'(root >> 1);

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [RTW-1:0] rem_p;
    logic [QB-1:0]  low_p;
    logic [QB-1:0]  quo_p;
    root_t          root_p;
    logic           neg_p, inv_p;
    logic [RTW:0]   acc;

    if (k == 0) begin : g_first
      assign rem_p  = RTW'(num[NUMW-1:QB]);
      assign low_p  = num[QB-1:0];
      assign quo_p  = '0;
      assign root_p = root;
      assign neg_p  = neg;
      assign inv_p  = inv_in;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign low_p  = low_q[k-1];
      assign quo_p  = quo_q[k-1];
      assign root_p = root_q[k-1];
      assign neg_p  = neg_q[k-1];
      assign inv_p  = inv_q[k-1];
    end

    assign acc = {rem_p, low_p[QB-1]};

    always_ff @(posedge clk) begin
      if (en[k]) begin
        low_q[k]  <= low_p << 1;
        root_q[k] <= root_p;
        neg_q[k]  <= neg_p;
        inv_q[k]  <= inv_p;
        if (acc >= {1'b0, root_p}) begin
          rem_q[k] <= RTW'(acc - {1'b0, root_p});
          quo_q[k] <= {quo_p[QB-2:0], 1'b1};
        end else begin
          rem_q[k] <= RTW'(acc);
          quo_q[k] <= {quo_p[QB-2:0], 1'b0};
        end
      end
    end
  end

  assign sat       = (quo_q[QB-1] > QB'(ONE_INT)) ? QB'(ONE_INT) : quo_q[QB-1];
  assign value     = neg_q[QB-1] ? -fx_t'({1'b0, sat}) : fx_t'({1'b0, sat});
  assign inv_out   = inv_q[QB-1];
  assign out_valid = v[QB-1];
endmodule
`default_nettype wire

// ===== src/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to unit quaternion (Shepperd's method) in signed Q1.14. One
// matrix word is taken per cycle unless the pipeline stalls, and each gives
// one quaternion word, in order, through the front end, the 31-stage square
// root of the 62-bit sum of squares, the per-component division lanes and
// the output register. Every stage only holds when the stage after it is full
// and stalled, so words keep entering while a result waits at the output. A
// matrix whose chosen radicand is not positive yields the identity quaternion
// with invalid set. Depends on rmq_pkg, rmq_if and the rmq modules.
`default_nettype none
module rotation_matrix_to_quaternion (
  input  logic              clk,
  input  logic              rst,
  rmq_mat_if.sink           mat,
  rmq_quat_if.source        quat
);
  import rmq_pkg::*;

  fx_t [8:0]       entry;
  logic            fr_valid, fr_ready;
  side_t           fr_side;
  logic [SW-1:0]   fr_n;
  logic            sq_valid, sq_ready;
  side_t           sq_side;
  root_t           sq_root;
  logic [3:0]      lane_ready, lane_valid, lane_inv;
  fx_t             lane_value [4];
  logic            out_en;
  logic            ov;
  fx_t             qx, qy, qz, qw;
  logic            qinv;

  assign entry = {mat.entry_8, mat.entry_7, mat.entry_6, mat.entry_5, mat.entry_4,
                  mat.entry_3, mat.entry_2, mat.entry_1, mat.entry_0};

  rmq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mat.valid),
    .in_ready  (mat.ready),
    .entry     (entry),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .side      (fr_side),
    .norm_sq   (fr_n)
  );

  rmq_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .side_in   (fr_side),
    .n_in      (fr_n),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .side_out  (sq_side),
    .root_out  (sq_root)
  );

  // lanes are identical and run in lockstep
  assign sq_ready = lane_ready[0];

  for (genvar i = 0; i < 4; i++) begin : g_lane
    rmq_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sq_valid),
      .in_ready  (lane_ready[i]),
      .mag       (sq_side.mag[i]),
      .root      (sq_root),
      .neg       (sq_side.neg[i]),
      .inv_in    (sq_side.inv),
      .out_valid (lane_valid[i]),
      .out_ready (out_en),
      .value     (lane_value[i]),
      .inv_out   (lane_inv[i])
    );
  end

  // merge the lanes into the output word, identity on a bad radicand
  assign out_en = !ov || quat.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (out_en) begin
      ov <= lane_valid[0];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      qinv <= lane_inv[0];
      if (lane_inv[0]) begin
        qx <= '0;
        qy <= '0;
        qz <= '0;
        qw <= fx_t'(ONE_FX);
      end else begin
        qx <= lane_value[0];
        qy <= lane_value[1];
        qz <= lane_value[2];
        qw <= lane_value[3];
      end
    end
  end

  assign quat.valid   = ov;
  assign quat.quat_x  = qx;
  assign quat.quat_y  = qy;
  assign quat.quat_z  = qz;
  assign quat.quat_w  = qw;
  assign quat.invalid = qinv;

`ifndef SYNTHESIS
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    lane_valid == {4{lane_valid[0]}} && lane_ready == {4{lane_ready[0]}})
    else $error("division lanes out of step");

  a_identity_on_invalid: assert property (@(posedge clk) disable iff (rst)
    quat.valid && quat.invalid |-> quat.quat_x == '0 && quat.quat_y == '0 &&
      quat.quat_z == '0 && quat.quat_w == fx_t'(ONE_FX))
    else $error("invalid word is not the identity quaternion");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    quat.valid && !quat.invalid |->
      quat.quat_x <= fx_t'(ONE_FX) && quat.quat_x >= -fx_t'(ONE_FX) &&
      quat.quat_w <= fx_t'(ONE_FX) && quat.quat_w >= -fx_t'(ONE_FX))
    else $error("quaternion component beyond one");

  a_merge_capture: assert property (@(posedge clk) disable iff (rst)
    out_en && lane_valid[0] |=> quat.valid)
    else $error("lane word lost at merge");
`endif
endmodule
`default_nettype wire
